FILE: src/slrg_pkg.sv
// Shared constants for the shuffled Lehmer random generator.
package slrg_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned MultW  = 15;
  localparam int unsigned ProdW  = ValueW + MultW;

  localparam logic [MultW-1:0]  LehmerMult = 15'd16807;
  localparam logic [ValueW-1:0] LehmerMod  = 31'h7FFF_FFFF;
  localparam int unsigned       WarmupExtra = 8;

endpackage

FILE: src/slrg_ram.sv
// Generic single write port RAM with registered read.
module slrg_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/slrg_lehmer.sv
// Lehmer step unit: registered 16807*x product, then folding reduction mod 2^31-1.
module slrg_lehmer (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [slrg_pkg::ValueW-1:0] x_i,
  output logic [slrg_pkg::ValueW-1:0] y_o
);

  logic [slrg_pkg::ProdW-1:0]  prod_q;
  logic [slrg_pkg::ProdW-1:0]  prod_d;
  logic [slrg_pkg::ValueW:0]   fold;
  logic [slrg_pkg::ValueW:0]   modulus;

  assign prod_d = slrg_pkg::ProdW'(slrg_pkg::LehmerMult) * slrg_pkg::ProdW'(x_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // 2^31 == 1 mod (2^31-1): add high part to low part, one correction
  assign modulus = {1'b0, slrg_pkg::LehmerMod};
  assign fold = {1'b0, prod_q[slrg_pkg::ValueW-1:0]}
              + (slrg_pkg::ValueW+1)'(prod_q[slrg_pkg::ProdW-1:slrg_pkg::ValueW]);

  always_comb begin
    if (fold >= modulus) begin
      y_o = slrg_pkg::ValueW'(fold - modulus);
    end else begin
      y_o = fold[slrg_pkg::ValueW-1:0];
    end
  end

endmodule

FILE: src/shuffled_lehmer_random_generator_top.sv
// Top level: Park-Miller generator with Bays-Durham shuffle table.
//
// Each accepted transaction returns one 31-bit value in 1..2^31-2 (unit fraction is
// value/2147483647). A normal draw keeps the block busy from acceptance to ready
// again: the table slot comes straight from comparing the previous pick with the
// constant slot boundaries, then ST_MUL does the 16807*x multiply with the table
// read, ST_RED the mod 2^31-1 reduction with the table write, and ST_PUSH hands the
// result to the output register, which shows it as ready returns. If the output
// register still holds a result that has not been taken, the last step waits for it.
// The first request after reset, or one with restart set, first reloads the generator
// from the seed register and runs TABLE_DEPTH+8 warm-up steps through the same
// multiplier, each through ST_INIT_MUL and ST_INIT_RED. A seed of 0 or 2^31-1 is
// replaced by 1. The seed is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle, which the block itself does not enforce.
module shuffled_lehmer_random_generator_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [slrg_pkg::ValueW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slrg_pkg::ValueW-1:0] value_o
);

  localparam int unsigned SlotW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + slrg_pkg::WarmupExtra);
  localparam logic [31:0] PickDiv = 32'(1 + (2147483646 / TABLE_DEPTH));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_RED,
    ST_MUL,
    ST_RED,
    ST_PUSH
  } state_e;

  state_e                      state_q;
  logic [slrg_pkg::ValueW-1:0] seed_q;
  logic [slrg_pkg::ValueW-1:0] gen_q;
  logic [slrg_pkg::ValueW-1:0] last_pick_q;
  logic [CntW-1:0]             cnt_q;
  logic                        out_valid_q;
  logic [slrg_pkg::ValueW-1:0] value_q;

  logic [slrg_pkg::ValueW-1:0] seed_fix;
  logic [slrg_pkg::ValueW-1:0] step_val;
  logic [slrg_pkg::ValueW-1:0] rd_data;
  logic [SlotW-1:0]            slot;
  logic                        need_init;
  logic                        mul_en;
  logic                        ram_we;
  logic [SlotW-1:0]            ram_waddr;
  logic                        ram_re;

  assign seed_fix = (seed_q == '0 || seed_q == slrg_pkg::LehmerMod)
                  ? slrg_pkg::ValueW'(1) : seed_q;
  assign need_init = restart_i || (last_pick_q == '0) || (gen_q == '0);

  // slot = last pick / PickDiv, from the constant boundaries k*PickDiv
  always_comb begin
    slot = '0;
    for (int unsigned k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, last_pick_q} >= 32'(k) * PickDiv) begin
        slot = SlotW'(k);
      end
    end
  end

  assign mul_en = (state_q == ST_INIT_MUL) || (state_q == ST_MUL);
  assign ram_re = (state_q == ST_MUL);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    if (state_q == ST_INIT_RED) begin
      ram_we    = (cnt_q < CntW'(TABLE_DEPTH));
      ram_waddr = cnt_q[SlotW-1:0];
    end else if (state_q == ST_RED) begin
      ram_we    = 1'b1;
    end
  end

  slrg_lehmer u_lehmer (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .x_i   (gen_q),
    .y_o   (step_val)
  );

  slrg_ram #(
    .Width (slrg_pkg::ValueW),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (step_val),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= slrg_pkg::ValueW'(1);
      gen_q       <= '0;
      last_pick_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (state_q == ST_PUSH && (!out_valid_q || out_ready_i)) begin
        value_q     <= last_pick_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (need_init) begin
              gen_q   <= seed_fix;
              cnt_q   <= CntW'(TABLE_DEPTH + slrg_pkg::WarmupExtra - 1);
              state_q <= ST_INIT_MUL;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_INIT_MUL: begin
          state_q <= ST_INIT_RED;
        end
        ST_INIT_RED: begin
          gen_q <= step_val;
          if (cnt_q == '0) begin
            // entry 0 is the last warm-up value and the first pick
            last_pick_q <= step_val;
            state_q     <= ST_MUL;
          end else begin
            cnt_q   <= cnt_q - CntW'(1);
            state_q <= ST_INIT_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_RED;
        end
        ST_RED: begin
          gen_q       <= step_val;
          last_pick_q <= rd_data;
          state_q     <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("block still ready after accepting a transaction");

  a_value_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o != '0) && (value_o != slrg_pkg::LehmerMod)
  ) else $error("result outside 1..2^31-2");

  a_gen_live: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> (gen_q != '0) && (last_pick_q != '0)
  ) else $error("draw started from uninitialised generator");

  a_slot_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> ({1'b0, slot} < (SlotW+1)'(TABLE_DEPTH))
  ) else $error("shuffle slot beyond table depth");

endmodule
